FILE: design/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg: shared types and codes of the meter record table
// Action and status codes, the request layout and the stored record layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mrt_pkg;

   // action codes
   localparam logic [1:0] ACT_REPORT  = 2'd0;
   localparam logic [1:0] ACT_SET_ABS = 2'd1;
   localparam logic [1:0] ACT_SET_OFS = 2'd2;
   localparam logic [1:0] ACT_QUERY   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_BAD_ID = 2'd2;

   localparam int CHANNELS = 2;

   // latched request
   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  meter_id;
      logic        channel_hot;
      logic [31:0] cold_reading;
      logic [31:0] hot_reading;
      logic [15:0] battery_mv;
      logic [31:0] report_time;
      logic [31:0] current_time;
      logic [31:0] abs_value;
      logic [31:0] cold_offset_in;
      logic [31:0] hot_offset_in;
   } req_type;

   // one stored record, channel 0 cold and channel 1 hot
   typedef struct packed {
      logic [CHANNELS-1:0][31:0] raw;
      logic [CHANNELS-1:0][31:0] offset;
      logic [CHANNELS-1:0][31:0] change;
      logic [31:0]               update;
      logic [15:0]               battery;
   } rec_type;

   // outcome of the ID lookup
   typedef struct packed {
      logic hit;
      logic any_free;
   } look_type;

endpackage

`default_nettype wire

FILE: design/mrt_slot_dir.sv
// ----------------------------------------------------------------------------
// mrt_slot_dir: slot directory of the meter record table
// Holds the meter ID of each slot, compares all of them against the request
// ID into registered hit and free vectors, then picks the slot to use.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_slot_dir
   import mrt_pkg::*;
#(
   parameter int SLOTS  = 8,
   parameter int SLOT_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        id,
   input  wire logic              capture,
   input  wire logic              claim,
   output look_type               look,
   output logic      [SLOT_W-1:0] slot
);

   logic [SLOTS-1:0][7:0]  ids_ff;
   logic [SLOTS-1:0]       hit_vec_ff;
   logic [SLOTS-1:0]       free_vec_ff;
   logic [SLOT_W-1:0]      first_hit;
   logic [SLOT_W-1:0]      first_free;

   // compare every slot against the request ID
   always_ff @(posedge clock) begin
      if (capture) begin
         for (int i = 0; i < SLOTS; i++) begin
            hit_vec_ff[i]  <= (ids_ff[i] == id);
            free_vec_ff[i] <= (ids_ff[i] == 8'd0);
         end
      end
   end

   // pick the lowest matching and the lowest free slot
   always_comb begin
      first_hit  = '0;
      first_free = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) first_hit = SLOT_W'(i);
         if (free_vec_ff[i]) first_free = SLOT_W'(i);
      end
   end

   assign look = {|hit_vec_ff, |free_vec_ff};
   assign slot = look.hit ? first_hit : first_free;

   // hold the IDs; a claim takes the chosen free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) ids_ff[i] <= 8'd0;
      end else if (claim) begin
         ids_ff[slot] <= id;
      end
   end

endmodule

`default_nettype wire

FILE: design/mrt_record_ram.sv
// ----------------------------------------------------------------------------
// mrt_record_ram: record store of the meter record table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_record_ram
   import mrt_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  rec_type                wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output rec_type                rd_data
);

   rec_type records_ff [DEPTH];
   rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) records_ff[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= records_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/mrt_rec_update.sv
// ----------------------------------------------------------------------------
// mrt_rec_update: record modify logic of the meter record table
// Applies one request to a record read from the store; a freshly claimed
// slot starts from an all-zero record.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_rec_update
   import mrt_pkg::*;
(
   input  req_type         req,
   input  wire logic       is_new,
   input  rec_type         rec_old,
   output rec_type         rec_new
);

   rec_type     base;
   logic [31:0] reading [CHANNELS];
   logic [32:0] diff;
   logic [31:0] diff_sat;

   assign base       = is_new ? '0 : rec_old;
   assign reading[0] = req.cold_reading;
   assign reading[1] = req.hot_reading;

   // offset for set absolute: wanted value less raw count, saturated
   always_comb begin
      diff = {req.abs_value[31], req.abs_value}
           - {base.raw[req.channel_hot][31], base.raw[req.channel_hot]};
      if (diff[32] != diff[31]) begin
         diff_sat = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         diff_sat = diff[31:0];
      end
   end

   // apply the action
   always_comb begin
      rec_new = base;
      unique case (req.action)
         ACT_REPORT: begin
            rec_new.battery = req.battery_mv;
            for (int c = 0; c < CHANNELS; c++) begin
               if (base.raw[c] != 32'd0 && base.raw[c] != reading[c]) begin
                  rec_new.change[c] = req.current_time;
               end
               rec_new.raw[c] = reading[c];
            end
            rec_new.update = (req.report_time != 32'd0) ? req.report_time
                                                        : req.current_time;
         end
         ACT_SET_ABS: begin
            rec_new.offset[req.channel_hot] = diff_sat;
         end
         ACT_SET_OFS: begin
            rec_new.offset[0] = req.cold_offset_in;
            rec_new.offset[1] = req.hot_offset_in;
            rec_new.update    = 32'd0;
         end
         ACT_QUERY: begin
            rec_new = base;
         end
         default: begin
            rec_new = base;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/meter_record_table.sv
// ----------------------------------------------------------------------------
// meter_record_table: keyed table of meter records
// Looks a meter up by ID, claims a free slot for a new one and applies a
// report, set absolute, set offsets or query request to its record.
// ----------------------------------------------------------------------------
// Use: a request enters on req_* (valid/ready) and gives exactly one result
// on rsp_* (valid/ready). One request is in work at a time: req_ready is
// high only while the block is idle.
// Steps: after a request is accepted the block does the ID compare, the
// slot pick and record read, the modify and write back, and the result
// formatting, in that order, and takes the next request only once it is
// idle again. A rejected ID or a full table skips the write back.
// Stall: the result waits in the output register while rsp_ready is low;
// a finished request then holds in the last step and the next request is
// not taken until the result register frees.
// Reset: clears the slot directory (every slot free) and the control state.
// The record store is not cleared: a slot's record is taken as zero when
// the slot is claimed, and the contents of unclaimed slots are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_record_table
   import mrt_pkg::*;
#(
   parameter int TABLE_SLOTS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic        [1:0]  req_action,
   input  wire logic        [7:0]  req_meter_id,
   input  wire logic               req_channel_hot,
   input  wire logic signed [31:0] req_cold_reading,
   input  wire logic signed [31:0] req_hot_reading,
   input  wire logic        [15:0] req_battery_mv,
   input  wire logic        [31:0] req_report_time,
   input  wire logic        [31:0] req_current_time,
   input  wire logic signed [31:0] req_abs_value,
   input  wire logic signed [31:0] req_cold_offset_in,
   input  wire logic signed [31:0] req_hot_offset_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic             [1:0]  rsp_status,
   output logic             [2:0]  rsp_slot,
   output logic             [30:0] rsp_adjusted_count,
   output logic signed      [31:0] rsp_offset_out,
   output logic             [31:0] rsp_last_update,
   output logic             [31:0] rsp_last_change,
   output logic             [15:0] rsp_battery_out
);

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SX_W   = (SLOT_W > 3) ? SLOT_W : 3;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MATCH = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_RMW   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              is_new_ff;
   logic [1:0]        status_ff;
   rec_type           nrec_ff;

   look_type          look;
   logic [SLOT_W-1:0] dir_slot;
   logic              bad_id;
   logic              claim;
   logic [1:0]        status_in;
   rec_type           ram_rd;
   rec_type           rec_new;
   logic              accept;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [2:0]        rsp_slot_ff;
   logic [30:0]       rsp_count_ff;
   logic [31:0]       rsp_offset_ff;
   logic [31:0]       rsp_update_ff;
   logic [31:0]       rsp_change_ff;
   logic [15:0]       rsp_battery_ff;

   logic [32:0]       sum;
   logic [30:0]       count_sat;
   logic [SX_W-1:0]   slot_x;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // latch the request
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.action         <= req_action;
         req_ff.meter_id       <= req_meter_id;
         req_ff.channel_hot    <= req_channel_hot;
         req_ff.cold_reading   <= req_cold_reading;
         req_ff.hot_reading    <= req_hot_reading;
         req_ff.battery_mv     <= req_battery_mv;
         req_ff.report_time    <= req_report_time;
         req_ff.current_time   <= req_current_time;
         req_ff.abs_value      <= req_abs_value;
         req_ff.cold_offset_in <= req_cold_offset_in;
         req_ff.hot_offset_in  <= req_hot_offset_in;
      end
   end

   mrt_slot_dir #(
      .SLOTS  (TABLE_SLOTS),
      .SLOT_W (SLOT_W)
   ) u_dir (
      .clock   (clock),
      .reset   (reset),
      .id      (req_ff.meter_id),
      .capture (state_ff == S_MATCH),
      .claim   (claim),
      .look    (look),
      .slot    (dir_slot)
   );

   // decide the slot outcome
   assign bad_id = (req_ff.meter_id == 8'd0);
   assign claim  = (state_ff == S_LOOK) && !bad_id && !look.hit && look.any_free;

   always_comb begin
      if (bad_id) begin
         status_in = ST_BAD_ID;
      end else if (look.hit || look.any_free) begin
         status_in = ST_OK;
      end else begin
         status_in = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         slot_ff   <= dir_slot;
         is_new_ff <= !look.hit;
         status_ff <= status_in;
      end
   end

   // the next request reads only after this write back, so no forwarding
   mrt_record_ram #(
      .DEPTH  (TABLE_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_RMW),
      .wr_addr (slot_ff),
      .wr_data (rec_new),
      .rd_en   (state_ff == S_LOOK),
      .rd_addr (dir_slot),
      .rd_data (ram_rd)
   );

   mrt_rec_update u_upd (
      .req     (req_ff),
      .is_new  (is_new_ff),
      .rec_old (ram_rd),
      .rec_new (rec_new)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_RMW) nrec_ff <= rec_new;
   end

   // sequence the request
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_MATCH;
         S_MATCH: state_in = S_LOOK;
         S_LOOK:  state_in = (status_in == ST_OK) ? S_RMW : S_FIN;
         S_RMW:   state_in = S_FIN;
         S_FIN:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // adjusted count of the chosen channel, clamped at 0 and saturated
   always_comb begin
      sum = {nrec_ff.raw[req_ff.channel_hot][31], nrec_ff.raw[req_ff.channel_hot]}
          + {nrec_ff.offset[req_ff.channel_hot][31], nrec_ff.offset[req_ff.channel_hot]};
      if (sum[32]) begin
         count_sat = '0;
      end else if (sum[31]) begin
         count_sat = '1;
      end else begin
         count_sat = sum[30:0];
      end
   end

   assign slot_x = SX_W'(slot_ff);

   // load and drop the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (state_ff == S_FIN && out_free) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && out_free) begin
         rsp_status_ff <= status_ff;
         if (status_ff == ST_OK) begin
            rsp_slot_ff    <= slot_x[2:0];
            rsp_count_ff   <= count_sat;
            rsp_offset_ff  <= nrec_ff.offset[req_ff.channel_hot];
            rsp_update_ff  <= nrec_ff.update;
            rsp_change_ff  <= nrec_ff.change[req_ff.channel_hot];
            rsp_battery_ff <= nrec_ff.battery;
         end else begin
            rsp_slot_ff    <= '0;
            rsp_count_ff   <= '0;
            rsp_offset_ff  <= '0;
            rsp_update_ff  <= '0;
            rsp_change_ff  <= '0;
            rsp_battery_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_adjusted_count = rsp_count_ff;
   assign rsp_offset_out     = rsp_offset_ff;
   assign rsp_last_update    = rsp_update_ff;
   assign rsp_last_change    = rsp_change_ff;
   assign rsp_battery_out    = rsp_battery_ff;

endmodule

`default_nettype wire

FILE: design/mrt_checker.sv
// ----------------------------------------------------------------------------
// mrt_checker: port-level checks of the meter record table
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [2:0]  rsp_slot,
   input wire logic [30:0] rsp_adjusted_count
);

   // no result straight after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one request in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // no result appears while the ID compare and slot lookup are still in work
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result too soon after request");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot) && $stable(rsp_adjusted_count))
      else $error("stalled result changed");

endmodule

bind meter_record_table mrt_checker u_mrt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_slot           (rsp_slot),
   .rsp_adjusted_count (rsp_adjusted_count)
);

`default_nettype wire
